### src/bta_pkg.sv
// Shared types and constants of the boundary-tag heap allocator.
package bta_pkg;

   // Request kinds.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Response status codes.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_OOM  = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_HEAP_BASE = 1'b0;
   localparam logic CSR_CHUNK     = 1'b1;

   // Tag constants and sizes in bytes.
   localparam logic [31:0] PROLOGUE_TAG = 32'd9;
   localparam logic [31:0] EPILOGUE_TAG = 32'd1;
   localparam logic [31:0] MIN_BLOCK    = 32'd16;
   localparam logic [31:0] ALIGN_MASK   = 32'hFFFF_FFF8;
   localparam int          INIT_CHUNK   = 4096;
   localparam logic [16:0] CHUNK_RESET  = 17'd4096;

   // One access of the tag store, addressed by byte offset.
   typedef struct packed {
      logic        we;
      logic [31:0] addr;
      logic [31:0] wdata;
   } mem_req_type;

   // Finished result handed from the sequencer to the output register.
   typedef struct packed {
      logic        valid;
      logic [31:0] block_address;
      logic [1:0]  status;
   } result_type;

endpackage

### src/bta_if.sv
// Request and response channel interfaces of the heap allocator.
interface bta_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [23:0] req_size;
   logic [31:0] free_address;
   modport source(output valid, req_type, req_size, free_address, input ready);
   modport sink(input valid, req_type, req_size, free_address, output ready);
endinterface

interface bta_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] block_address;
   logic [1:0]  status;
   modport source(output valid, block_address, status, input ready);
   modport sink(input valid, block_address, status, output ready);
endinterface

### src/bta_ram.sv
// Generic single-port RAM with a registered read.
module bta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and read at the same address; the read returns the old word.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### src/bta_ctrl.sv
// Sequencer that walks, splits and merges the boundary tags in the tag store.
module bta_ctrl #(
   parameter int HEAP_BYTES = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [23:0]          req_size,
   input  logic [31:0]          free_address,
   input  logic [31:0]          heap_base,
   input  logic [16:0]          chunk_bytes,
   output bta_pkg::mem_req_type mem_req,
   input  logic [31:0]          mem_rdata,
   output bta_pkg::result_type  result,
   input  logic                 result_taken
);
   import bta_pkg::*;

   localparam int TAG_WORDS = HEAP_BYTES / 4;
   localparam int CLR_W     = $clog2(TAG_WORDS);
   localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(TAG_WORDS - 1);
   localparam logic [32:0] HEAP_LIM = 33'(HEAP_BYTES);
   localparam bit INIT_FITS = (16 + INIT_CHUNK) <= HEAP_BYTES;
   localparam logic [31:0] INIT_SIZE = 32'(INIT_CHUNK);
   localparam int WN = 5;

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_WR     = 4'd1;
   localparam logic [3:0] S_IDLE   = 4'd2;
   localparam logic [3:0] S_FF_RD  = 4'd3;
   localparam logic [3:0] S_FF_CHK = 4'd4;
   localparam logic [3:0] S_GROW   = 4'd5;
   localparam logic [3:0] S_MG_RD  = 4'd6;
   localparam logic [3:0] S_MG_OWN = 4'd7;
   localparam logic [3:0] S_MG_NXT = 4'd8;
   localparam logic [3:0] S_MG_PF  = 4'd9;
   localparam logic [3:0] S_MG_PH  = 4'd10;
   localparam logic [3:0] S_PL_RD  = 4'd11;
   localparam logic [3:0] S_PL     = 4'd12;
   localparam logic [3:0] S_FR_RD  = 4'd13;
   localparam logic [3:0] S_FR_CHK = 4'd14;
   localparam logic [3:0] S_DONE   = 4'd15;

   logic [3:0]       state_ff, state_in;
   logic [3:0]       ret_ff, ret_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic [2:0]       wi_ff, wi_in;
   logic [2:0]       wl_ff, wl_in;
   logic [31:0]      wa_ff [WN];
   logic [31:0]      wa_in [WN];
   logic [31:0]      wd_ff [WN];
   logic [31:0]      wd_in [WN];
   logic [31:0]      brk_ff, brk_in;
   logic [31:0]      bp_ff, bp_in;
   logic [31:0]      a_ff, a_in;
   logic [31:0]      own_ff, own_in;
   logic [31:0]      acc_ff, acc_in;
   logic [31:0]      pb_ff, pb_in;
   logic             nused_ff, nused_in;
   logic             free_ff, free_in;
   logic [31:0]      res_addr_ff, res_addr_in;
   logic [1:0]       res_status_ff, res_status_in;

   logic [31:0] rd_size;
   logic        rd_used;
   logic [17:0] chunk_round;
   logic [31:0] chunk_eff;
   logic [31:0] grow_n;
   logic [31:0] sum_p;
   logic [31:0] next_bp;
   logic [3:0]  after_merge;

   assign rd_size = mem_rdata & ALIGN_MASK;
   assign rd_used = mem_rdata[0];

   // Chunk size rounded up to the alignment, never below a minimum block.
   always_comb begin
      chunk_round = (18'(chunk_bytes) + 18'd7) & ~18'd7;
      chunk_eff   = (chunk_round < 18'd16) ? MIN_BLOCK : 32'(chunk_round);
   end

   assign grow_n      = (a_ff > chunk_eff) ? a_ff : chunk_eff;
   assign sum_p       = acc_ff + rd_size;
   assign next_bp     = bp_ff + rd_size;
   assign after_merge = free_ff ? S_DONE : S_PL_RD;

   // Main sequencer.
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      clr_in        = clr_ff;
      wi_in         = wi_ff;
      wl_in         = wl_ff;
      wa_in         = wa_ff;
      wd_in         = wd_ff;
      brk_in        = brk_ff;
      bp_in         = bp_ff;
      a_in          = a_ff;
      own_in        = own_ff;
      acc_in        = acc_ff;
      pb_in         = pb_ff;
      nused_in      = nused_ff;
      free_in       = free_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      mem_req.we    = 1'b0;
      mem_req.addr  = 32'd0;
      mem_req.wdata = 32'd0;
      req_ready     = 1'b0;

      unique case (state_ff)
         // Zero every word, then lay down the prologue, the first chunk if it fits, and the epilogue.
         S_CLR: begin
            mem_req.we   = 1'b1;
            mem_req.addr = 32'(clr_ff) << 2;
            if (clr_ff == CLR_LAST) begin
               wa_in[0] = 32'd4;
               wd_in[0] = PROLOGUE_TAG;
               wa_in[1] = 32'd8;
               wd_in[1] = PROLOGUE_TAG;
               wa_in[2] = 32'd12;
               if (INIT_FITS) begin
                  wd_in[2] = INIT_SIZE;
                  wa_in[3] = 32'd16 + INIT_SIZE - 32'd8;
                  wd_in[3] = INIT_SIZE;
                  wa_in[4] = 32'd16 + INIT_SIZE - 32'd4;
                  wd_in[4] = EPILOGUE_TAG;
                  wl_in    = 3'd4;
                  brk_in   = 32'd16 + INIT_SIZE;
               end else begin
                  wd_in[2] = EPILOGUE_TAG;
                  wl_in    = 3'd2;
                  brk_in   = 32'd16;
               end
               wi_in    = 3'd0;
               ret_in   = S_IDLE;
               state_in = S_WR;
            end else begin
               clr_in = clr_ff + CLR_W'(1);
            end
         end

         // Play out the queued tag writes, one per cycle.
         S_WR: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = wa_ff[wi_ff];
            mem_req.wdata = wd_ff[wi_ff];
            if (wi_ff == wl_ff) begin
               wi_in    = 3'd0;
               state_in = ret_ff;
            end else begin
               wi_in = wi_ff + 3'd1;
            end
         end

         // Take a request and size it.
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_addr_in   = 32'd0;
               res_status_in = ST_OK;
               if (req_type == REQ_FREE) begin
                  bp_in    = free_address - heap_base;
                  free_in  = 1'b1;
                  state_in = S_FR_RD;
               end else if (req_size == 24'd0) begin
                  res_status_in = ST_ZERO;
                  state_in      = S_DONE;
               end else begin
                  a_in     = (req_size < 24'd8) ? MIN_BLOCK
                           : ((32'(req_size) + 32'd15) & ALIGN_MASK);
                  bp_in    = 32'd8;
                  free_in  = 1'b0;
                  state_in = S_FF_RD;
               end
            end
         end

         // First-fit walk: read the header of the current block.
         S_FF_RD: begin
            if (bp_ff >= brk_ff) begin
               state_in = S_GROW;
            end else begin
               mem_req.addr = bp_ff - 32'd4;
               state_in     = S_FF_CHK;
            end
         end

         S_FF_CHK: begin
            if (rd_size == 32'd0) begin
               state_in = S_GROW;
            end else if (!rd_used && (a_ff <= rd_size)) begin
               state_in = S_PL_RD;
            end else if (next_bp <= bp_ff) begin
               state_in = S_GROW;
            end else begin
               bp_in    = next_bp;
               state_in = S_FF_RD;
            end
         end

         // Extend the break with a new free block and a fresh epilogue, or report out of memory.
         S_GROW: begin
            if (33'(brk_ff) + 33'(grow_n) > HEAP_LIM) begin
               res_status_in = ST_OOM;
               state_in      = S_DONE;
            end else begin
               bp_in    = brk_ff;
               brk_in   = brk_ff + grow_n;
               wa_in[0] = brk_ff - 32'd4;
               wd_in[0] = grow_n;
               wa_in[1] = brk_ff + grow_n - 32'd8;
               wd_in[1] = grow_n;
               wa_in[2] = brk_ff + grow_n - 32'd4;
               wd_in[2] = EPILOGUE_TAG;
               wl_in    = 3'd2;
               wi_in    = 3'd0;
               ret_in   = S_MG_RD;
               state_in = S_WR;
            end
         end

         // Merge: own header, next header, previous footer, previous header.
         S_MG_RD: begin
            mem_req.addr = bp_ff - 32'd4;
            state_in     = S_MG_OWN;
         end

         S_MG_OWN: begin
            own_in       = rd_size;
            mem_req.addr = next_bp - 32'd4;
            state_in     = S_MG_NXT;
         end

         S_MG_NXT: begin
            nused_in     = rd_used;
            acc_in       = own_ff + (rd_used ? 32'd0 : rd_size);
            mem_req.addr = bp_ff - 32'd8;
            state_in     = S_MG_PF;
         end

         S_MG_PF: begin
            pb_in        = bp_ff - rd_size;
            mem_req.addr = bp_ff - rd_size - 32'd4;
            state_in     = S_MG_PH;
         end

         S_MG_PH: begin
            wi_in  = 3'd0;
            wl_in  = 3'd1;
            ret_in = after_merge;
            if (rd_used && nused_ff) begin
               state_in = after_merge;
            end else if (rd_used) begin
               wa_in[0] = bp_ff - 32'd4;
               wd_in[0] = acc_ff;
               wa_in[1] = bp_ff + acc_ff - 32'd8;
               wd_in[1] = acc_ff;
               state_in = S_WR;
            end else if (nused_ff) begin
               wa_in[0] = bp_ff + own_ff - 32'd8;
               wd_in[0] = sum_p;
               wa_in[1] = pb_ff - 32'd4;
               wd_in[1] = sum_p;
               bp_in    = pb_ff;
               state_in = S_WR;
            end else begin
               wa_in[0] = pb_ff - 32'd4;
               wd_in[0] = sum_p;
               wa_in[1] = pb_ff + sum_p - 32'd8;
               wd_in[1] = sum_p;
               bp_in    = pb_ff;
               state_in = S_WR;
            end
         end

         // Place: mark the block used and split off a free tail if large enough.
         S_PL_RD: begin
            mem_req.addr = bp_ff - 32'd4;
            state_in     = S_PL;
         end

         S_PL: begin
            res_addr_in = heap_base + bp_ff;
            wi_in       = 3'd0;
            ret_in      = S_DONE;
            state_in    = S_WR;
            wa_in[0]    = bp_ff - 32'd4;
            if ((rd_size >= a_ff) && (rd_size - a_ff >= MIN_BLOCK)) begin
               wd_in[0] = a_ff | 32'd1;
               wa_in[1] = bp_ff + a_ff - 32'd8;
               wd_in[1] = a_ff | 32'd1;
               wa_in[2] = bp_ff + a_ff - 32'd4;
               wd_in[2] = rd_size - a_ff;
               wa_in[3] = bp_ff + rd_size - 32'd8;
               wd_in[3] = rd_size - a_ff;
               wl_in    = 3'd3;
            end else begin
               wd_in[0] = rd_size | 32'd1;
               wa_in[1] = bp_ff + rd_size - 32'd8;
               wd_in[1] = rd_size | 32'd1;
               wl_in    = 3'd1;
            end
         end

         // Free: check the offset, then the header.
         S_FR_RD: begin
            if ((bp_ff[2:0] == 3'd0) && (bp_ff >= 32'd16) && (bp_ff < brk_ff)) begin
               mem_req.addr = bp_ff - 32'd4;
               state_in     = S_FR_CHK;
            end else begin
               state_in = S_DONE;
            end
         end

         S_FR_CHK: begin
            if (rd_used && (rd_size != 32'd0) &&
                (33'(bp_ff) + 33'(rd_size) - 33'd4 <= 33'(brk_ff))) begin
               wa_in[0] = bp_ff - 32'd4;
               wd_in[0] = rd_size;
               wa_in[1] = next_bp - 32'd8;
               wd_in[1] = rd_size;
               wl_in    = 3'd1;
               wi_in    = 3'd0;
               ret_in   = S_MG_RD;
               state_in = S_WR;
            end else begin
               state_in = S_DONE;
            end
         end

         // Hold the result until the output register takes it.
         S_DONE: begin
            if (result_taken) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result.valid         = (state_ff == S_DONE);
   assign result.block_address = res_addr_ff;
   assign result.status        = res_status_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         wi_ff    <= 3'd0;
         brk_ff   <= 32'd16;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         wi_ff    <= wi_in;
         brk_ff   <= brk_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      wl_ff         <= wl_in;
      wa_ff         <= wa_in;
      wd_ff         <= wd_in;
      bp_ff         <= bp_in;
      a_ff          <= a_in;
      own_ff        <= own_in;
      acc_ff        <= acc_in;
      pb_ff         <= pb_in;
      nused_ff      <= nused_in;
      free_ff       <= free_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
   end

endmodule

### src/boundary_tag_heap_allocator_unit.sv
// Top level of the boundary-tag heap allocator: registers, tag store and output stage.
// An allocate runs the first-fit walk in the sequencer, one tag-store read per block that
// the walk passes; growing the heap and merging adds to that. A free stops when its offset
// or its header is refused and otherwise releases and merges the block; a zero-size
// allocate skips the walk. The result word goes out through the output register, one
// request is in work at a time, and the next is taken while that word waits in the
// output register. Reset is synchronous; afterwards a clearing pass zeroes the tag store
// and writes the initial heap.
module boundary_tag_heap_allocator_unit #(
   parameter int HEAP_BYTES = 65536
) (
   input  logic         clock,
   input  logic         reset,
   bta_req_if.sink      req,
   bta_rsp_if.source    rsp,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);
   import bta_pkg::*;

   localparam int TAG_WORDS = HEAP_BYTES / 4;
   localparam int ADDR_W    = $clog2(TAG_WORDS);

   logic [31:0] heap_base_ff, heap_base_in;
   logic [16:0] chunk_ff, chunk_in;
   logic        rd_ok_ff, rd_ok_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   mem_req_type mem_req;
   result_type  result;
   logic [29:0] word;
   logic        in_range;
   logic [31:0] ram_rdata;
   logic [31:0] mem_rdata;
   logic        result_taken;

   // Configuration registers.
   always_comb begin
      heap_base_in = heap_base_ff;
      chunk_in     = chunk_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HEAP_BASE: heap_base_in = csr_wdata;
            CSR_CHUNK:     chunk_in     = csr_wdata[16:0];
            default:       heap_base_in = heap_base_ff;
         endcase
      end
   end

   // Accesses beyond the tag store read as zero and drop their writes.
   assign word      = mem_req.addr[31:2];
   assign in_range  = word < 30'(TAG_WORDS);
   assign rd_ok_in  = in_range;
   assign mem_rdata = rd_ok_ff ? ram_rdata : 32'd0;

   bta_ram #(
      .WIDTH(32),
      .DEPTH(TAG_WORDS)
   ) u_tags (
      .clock (clock),
      .we    (mem_req.we && in_range),
      .addr  (word[ADDR_W-1:0]),
      .wdata (mem_req.wdata),
      .rdata (ram_rdata)
   );

   bta_ctrl #(
      .HEAP_BYTES(HEAP_BYTES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req.valid),
      .req_ready    (req.ready),
      .req_type     (req.req_type),
      .req_size     (req.req_size),
      .free_address (req.free_address),
      .heap_base    (heap_base_ff),
      .chunk_bytes  (chunk_ff),
      .mem_req      (mem_req),
      .mem_rdata    (mem_rdata),
      .result       (result),
      .result_taken (result_taken)
   );

   // Output register: loads when empty or when the held word is taken.
   assign result_taken = result.valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (result_taken) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = result.block_address;
         rsp_status_in = result.status;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.block_address = rsp_addr_ff;
   assign rsp.status        = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= 32'd0;
         chunk_ff     <= CHUNK_RESET;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         heap_base_ff <= heap_base_in;
         chunk_ff     <= chunk_in;
         rd_ok_ff     <= rd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

### src/bta_checker.sv
// Port-level checks of the heap allocator and their binding to the top level.
module bta_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_block_address,
   input logic [1:0]  rsp_status
);
   import bta_pkg::*;

   // A held response stays valid and keeps its address until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_address))
      else $error("response word changed while stalled");

   // Only defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_ZERO || rsp_status == ST_OOM))
      else $error("undefined status code");

   // A failed allocate returns a null address.
   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_block_address == 32'd0)
      else $error("non-zero address with failure status");

   // One request at a time: no request is taken right after another.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on consecutive cycles");

   // The clearing pass follows reset, so no request is taken just after it.
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request port ready during clearing pass");

endmodule

bind boundary_tag_heap_allocator_unit bta_checker u_bta_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_block_address (rsp.block_address),
   .rsp_status        (rsp.status)
);
